// ===== hw/rtl/ibmw_pkg.sv =====
// Shared types, codes and constants for the indirect block map walker.
// No dependencies; imported by every module of the block.
`default_nettype none

package ibmw_pkg;

	localparam int SLOT_COUNT = 13;
	localparam int SLOT_AW    = $clog2(SLOT_COUNT);
	localparam int SLOT_W     = 24;
	localparam int BLK_W      = 32;
	localparam int WORD_W     = 10;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int OP_W       = 2;

	// operations
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_XLATE = 2'd1;
	localparam logic [OP_W-1:0] OP_RESP  = 2'd2;

	// result kinds
	localparam logic KIND_REQ  = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTERS_LOG2 = 2'd1;

	localparam logic [CFG_W-1:0] DIRECT_COUNT_RST  = 4'd10;
	localparam logic [CFG_W-1:0] POINTERS_LOG2_RST = 4'd8;
	localparam logic [CFG_W-1:0] MAX_DIRECT        = CFG_W'(SLOT_COUNT - 3);
	localparam logic [CFG_W-1:0] MIN_PL            = 4'd7;
	localparam logic [CFG_W-1:0] MAX_PL            = 4'd10;

	// classification of a logical block, made ahead of the slot read
	typedef struct packed {
		logic               direct;
		logic               oor;
		logic [1:0]         levels;
		logic [BLK_W-1:0]   offset;
		logic [SLOT_AW-1:0] slot_addr;
	} dec_t;

	function automatic logic [CFG_W-1:0] eff_direct(input logic [CFG_W-1:0] v);
		if (v > MAX_DIRECT)
			return MAX_DIRECT;
		return v;
	endfunction

	function automatic logic [CFG_W-1:0] eff_log2(input logic [CFG_W-1:0] v);
		if (v < MIN_PL)
			return MIN_PL;
		if (v > MAX_PL)
			return MAX_PL;
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ibmw_slot_ram.sv =====
// Inode address slot store: write on load, registered read on translate.
// Per-entry valid bits give the all-zero reset. Uses ibmw_pkg.
`default_nettype none

module ibmw_slot_ram (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [ibmw_pkg::SLOT_AW-1:0] wr_addr,
	input  wire logic [ibmw_pkg::SLOT_W-1:0]  wr_data,
	input  wire logic                       rd_en,
	input  wire logic [ibmw_pkg::SLOT_AW-1:0] rd_addr,
	output logic      [ibmw_pkg::SLOT_W-1:0]  rd_data
);
	import ibmw_pkg::*;

	logic [SLOT_W-1:0]     mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] vld_q;
	logic [SLOT_W-1:0]     rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/ibmw_decode.sv =====
// Logical block classification: direct, single/double/triple, or beyond reach.
// Gives the slot to read and the offset inside the subtree. Uses ibmw_pkg.
`default_nettype none

module ibmw_decode (
	input  wire logic [ibmw_pkg::BLK_W-1:0] lbn,
	input  wire logic [ibmw_pkg::CFG_W-1:0] direct_count,
	input  wire logic [ibmw_pkg::CFG_W-1:0] pointers_log2,
	output ibmw_pkg::dec_t                  dec
);
	import ibmw_pkg::*;

	logic [4:0]       sh1, sh2, sh3;
	logic [BLK_W-1:0] per, per2, x1, x2, x3;
	logic             fits1, fits2, beyond;

	always_comb begin
		sh1  = 5'(pointers_log2);
		sh2  = 5'({pointers_log2, 1'b0});
		sh3  = sh1 + sh2;
		per  = BLK_W'(1) << sh1;
		per2 = BLK_W'(1) << sh2;
		x1   = lbn - BLK_W'(direct_count);
		x2   = x1 - per;
		// x1 less both the single and double reach, side by side with x2
		x3   = x1 - (per + per2);
		fits1  = (x1 >> sh1) == '0;
		fits2  = (x2 >> sh2) == '0;
		beyond = (x3 >> sh3) != '0;

		dec.direct    = lbn < BLK_W'(direct_count);
		dec.oor       = 1'b0;
		dec.levels    = 2'd0;
		dec.offset    = '0;
		dec.slot_addr = lbn[SLOT_AW-1:0];
		if (!dec.direct) begin
			if (fits1) begin
				dec.levels    = 2'd1;
				dec.offset    = x1;
				dec.slot_addr = SLOT_AW'(direct_count);
			end else if (fits2) begin
				dec.levels    = 2'd2;
				dec.offset    = x2;
				dec.slot_addr = SLOT_AW'(direct_count) + SLOT_AW'(1);
			end else if (beyond) begin
				dec.oor       = 1'b1;
				dec.slot_addr = SLOT_AW'(direct_count);
			end else begin
				dec.levels    = 2'd3;
				dec.offset    = x3;
				dec.slot_addr = SLOT_AW'(direct_count) + SLOT_AW'(2);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ibmw_walk.sv =====
// Walk state and result register: turns a staged item into a pointer
// request or a finished translation. Uses ibmw_pkg.
`default_nettype none

module ibmw_walk (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s1_valid,
	input  wire logic [ibmw_pkg::OP_W-1:0]   op,
	input  wire ibmw_pkg::dec_t              dec,
	input  wire logic [ibmw_pkg::SLOT_W-1:0] slot_data,
	input  wire logic [ibmw_pkg::BLK_W-1:0]  read_value,
	input  wire logic                        read_ok,
	input  wire logic [ibmw_pkg::CFG_W-1:0]  pointers_log2,
	input  wire logic                        result_stall,
	output logic                             advance,
	output logic                             result_valid,
	output logic                             result_kind,
	output logic [ibmw_pkg::BLK_W-1:0]       request_block,
	output logic [ibmw_pkg::WORD_W-1:0]      request_word,
	output logic [ibmw_pkg::BLK_W-1:0]       physical_block,
	output logic                             out_of_range
);
	import ibmw_pkg::*;

	logic             busy_q, busy_d;
	logic [1:0]       lv_q, lv_d;
	logic [BLK_W-1:0] off_q, off_d;

	logic              emit, kind, oor;
	logic [BLK_W-1:0]  blk, phys;
	logic [WORD_W-1:0] word;
	logic              fire;

	function automatic logic [WORD_W-1:0] widx(input logic [BLK_W-1:0] off,
			input logic [1:0] lv, input logic [CFG_W-1:0] pl);
		logic [4:0]        sh;
		logic [WORD_W:0]   mask;
		case (lv)
			2'd2:    sh = 5'(pl);
			2'd3:    sh = 5'({pl, 1'b0});
			default: sh = 5'd0;
		endcase
		mask = (WORD_W'(1) + 11'd0) << pl;
		mask = mask - 11'd1;
		return WORD_W'(off >> sh) & mask[WORD_W-1:0];
	endfunction

	assign advance = !result_valid || !result_stall;
	assign fire    = s1_valid && advance;

	always_comb begin
		emit   = 1'b0;
		kind   = KIND_DONE;
		blk    = '0;
		word   = '0;
		phys   = '0;
		oor    = 1'b0;
		busy_d = busy_q;
		lv_d   = lv_q;
		off_d  = off_q;
		case (op)
			OP_XLATE: begin
				busy_d = 1'b0;
				lv_d   = 2'd0;
				emit   = 1'b1;
				if (dec.direct) begin
					phys = BLK_W'(slot_data);
				end else if (dec.oor) begin
					oor = 1'b1;
				end else if (slot_data != '0) begin
					busy_d = 1'b1;
					lv_d   = dec.levels;
					off_d  = dec.offset;
					kind   = KIND_REQ;
					blk    = BLK_W'(slot_data);
					word   = widx(dec.offset, dec.levels, pointers_log2);
				end
			end
			OP_RESP: begin
				if (busy_q) begin
					emit = 1'b1;
					if (!read_ok || read_value == '0 || lv_q <= 2'd1) begin
						busy_d = 1'b0;
						lv_d   = 2'd0;
						phys   = read_ok ? read_value : '0;
					end else begin
						lv_d = lv_q - 2'd1;
						kind = KIND_REQ;
						blk  = read_value;
						word = widx(off_q, lv_q - 2'd1, pointers_log2);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			lv_q         <= 2'd0;
			off_q        <= '0;
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= fire && emit;
			if (fire) begin
				busy_q <= busy_d;
				lv_q   <= lv_d;
				off_q  <= off_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			result_kind    <= kind;
			request_block  <= blk;
			request_word   <= word;
			physical_block <= phys;
			out_of_range   <= oor;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/indirect_block_map_walker.sv =====
// Top level of the indirect block map walker: config registers, input stage,
// slot store, decode and walk. Uses ibmw_pkg, ibmw_slot_ram, ibmw_decode, ibmw_walk.
//
//   channel  handshake                 payload
//   item     item_valid / item_stall   operation, slot_index, slot_value,
//                                      logical_block, read_value, read_ok
//   result   result_valid / result_stall  result_kind, request_block,
//                                      request_word, physical_block, out_of_range
//   cfg      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while results are not stalled; an item goes through
// the input stage (which holds the registered slot read) and then the result
// register before its result is offered.
// item_stall rises only while the input stage is full and the result register
// holds a result that is stalled. Reset clears slots (valid bits), walk state
// and configuration to 10 direct slots and 256 pointers per block.
`default_nettype none

module indirect_block_map_walker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic [ibmw_pkg::OP_W-1:0]       operation,
	input  wire logic [3:0]                      slot_index,
	input  wire logic [ibmw_pkg::SLOT_W-1:0]     slot_value,
	input  wire logic [ibmw_pkg::BLK_W-1:0]      logical_block,
	input  wire logic [ibmw_pkg::BLK_W-1:0]      read_value,
	input  wire logic                            read_ok,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic                                 result_kind,
	output logic [ibmw_pkg::BLK_W-1:0]           request_block,
	output logic [ibmw_pkg::WORD_W-1:0]          request_word,
	output logic [ibmw_pkg::BLK_W-1:0]           physical_block,
	output logic                                 out_of_range,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ibmw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ibmw_pkg::CFG_W-1:0]      cfg_data
);
	import ibmw_pkg::*;

	logic [CFG_W-1:0] direct_count_q, pointers_log2_q;
	logic [CFG_W-1:0] d_eff, pl_eff;

	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	dec_t              dec_s1;
	logic [BLK_W-1:0]  read_value_s1;
	logic              read_ok_s1;

	dec_t              dec;
	logic              accept, advance;
	logic              wr_en;
	logic [SLOT_W-1:0] slot_data;

	assign cfg_ready = 1'b1;
	assign d_eff     = eff_direct(direct_count_q);
	assign pl_eff    = eff_log2(pointers_log2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_count_q  <= DIRECT_COUNT_RST;
			pointers_log2_q <= POINTERS_LOG2_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DIRECT_COUNT:  direct_count_q  <= cfg_data;
				CFG_POINTERS_LOG2: pointers_log2_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign wr_en      = accept && operation == OP_LOAD && slot_index < 4'(SLOT_COUNT);

	ibmw_decode u_decode (
		.lbn           (logical_block),
		.direct_count  (d_eff),
		.pointers_log2 (pl_eff),
		.dec           (dec)
	);

	// slot store is written and read as the item is taken, in item order
	ibmw_slot_ram u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (slot_index[SLOT_AW-1:0]),
		.wr_data (slot_value),
		.rd_en   (accept && operation == OP_XLATE),
		.rd_addr (dec.slot_addr),
		.rd_data (slot_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!item_stall)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1         <= operation;
			dec_s1        <= dec;
			read_value_s1 <= read_value;
			read_ok_s1    <= read_ok;
		end
	end

	ibmw_walk u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s1_valid       (valid_s1),
		.op             (op_s1),
		.dec            (dec_s1),
		.slot_data      (slot_data),
		.read_value     (read_value_s1),
		.read_ok        (read_ok_s1),
		.pointers_log2  (pl_eff),
		.result_stall   (result_stall),
		.advance        (advance),
		.result_valid   (result_valid),
		.result_kind    (result_kind),
		.request_block  (request_block),
		.request_word   (request_word),
		.physical_block (physical_block),
		.out_of_range   (out_of_range)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ibmw_checker.sv =====
// Port-level checks for the indirect block map walker, bound to the top level.
// Uses ibmw_pkg for result kind codes.
`default_nettype none

module ibmw_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_stall,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic                          result_kind,
	input wire logic [ibmw_pkg::BLK_W-1:0]    request_block,
	input wire logic [ibmw_pkg::WORD_W-1:0]   request_word,
	input wire logic [ibmw_pkg::BLK_W-1:0]    physical_block,
	input wire logic                          out_of_range
);
	import ibmw_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_kind)
			&& $stable(request_block) && $stable(request_word)
			&& $stable(physical_block) && $stable(out_of_range))
		else $error("stalled result changed");

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stall without stalled result");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_DONE |-> request_block == '0
			&& request_word == '0)
		else $error("finished result carries request fields");

	a_req_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_REQ |-> physical_block == '0
			&& !out_of_range && request_block != '0)
		else $error("bad request result");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_of_range |-> physical_block == '0)
		else $error("out of range with nonzero block");

endmodule

bind indirect_block_map_walker ibmw_checker u_ibmw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_stall     (item_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.result_kind    (result_kind),
	.request_block  (request_block),
	.request_word   (request_word),
	.physical_block (physical_block),
	.out_of_range   (out_of_range)
);

`default_nettype wire

// ===== tb/indirect_block_map_walker_tb.sv =====
// Self-checking testbench for indirect_block_map_walker: a directed table, then random
// slot loads, translations and pointer walks checked against an in-bench walk predictor.
// Depends on ibmw_pkg and the indirect_block_map_walker RTL only.
`timescale 1ns / 1ps

module indirect_block_map_walker_tb;

	import ibmw_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 221;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 300000;

	// register settings per random phase; raw extremes included on purpose
	localparam logic [CFG_W-1:0] PHASE_DC [PHASES] = '{4'd1, 4'd15, 4'd0, 4'd10, 4'd4, 4'd7};
	localparam logic [CFG_W-1:0] PHASE_PL [PHASES] = '{4'd7, 4'd10, 4'd0, 4'd15, 4'd9, 4'd8};

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [3:0]        idx;
		logic [SLOT_W-1:0] sval;
		logic [BLK_W-1:0]  lbn;
		logic [BLK_W-1:0]  rv;
		logic              ok;
	} map_item_t;

	localparam int ITEM_W = $bits(map_item_t);

	typedef struct packed {
		logic              kind;
		logic [BLK_W-1:0]  blk;
		logic [WORD_W-1:0] word;
		logic [BLK_W-1:0]  phys;
		logic              oor;
	} map_res_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_DONE, ROW_REQ} row_chk_e;

	// ROW_DONE: va = physical block, vb = out of range; ROW_REQ: va = block, vb = word
	typedef struct packed {
		map_item_t         it;
		row_chk_e          chk;
		logic [BLK_W-1:0]  va;
		logic [WORD_W-1:0] vb;
	} dir_row_t;

	// runs on reset config: 10 direct slots, 256 pointers per block
	localparam dir_row_t DIRECTED [25] = '{
		//  op        idx  sval       lbn           rv           ok
		'{'{OP_XLATE, 0,  24'h0,      0,            0,            0}, ROW_DONE, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      32'hFFFFFFFF, 0,            0}, ROW_DONE, 0, 1},
		'{'{OP_RESP,  0,  24'h0,      0,            5,            1}, ROW_QUIET, 0, 0},
		'{'{OP_UNUSED, 3, 24'h5,      7,            7,            1}, ROW_QUIET, 0, 0},
		'{'{OP_LOAD,  15, 24'hFFFFFF, 0,            0,            0}, ROW_QUIET, 0, 0},
		'{'{OP_LOAD,  0,  24'hFFFFFF, 0,            0,            0}, ROW_QUIET, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      0,            0,            0}, ROW_DONE, 32'hFFFFFF, 0},
		'{'{OP_XLATE, 0,  24'h0,      10,           0,            0}, ROW_DONE, 0, 0},
		'{'{OP_LOAD,  10, 24'h000123, 0,            0,            0}, ROW_PREDICT, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      15,           0,            0}, ROW_REQ, 32'h123, 5},
		'{'{OP_RESP,  0,  24'h0,      0,            32'hDEADBEEF, 1}, ROW_DONE, 32'hDEADBEEF, 0},
		'{'{OP_LOAD,  11, 24'hABCDEF, 0,            0,            0}, ROW_PREDICT, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      1041,         0,            0}, ROW_REQ, 32'hABCDEF, 3},
		'{'{OP_LOAD,  4,  24'h000001, 0,            0,            0}, ROW_PREDICT, 0, 0},
		'{'{OP_RESP,  0,  24'h0,      0,            32'h777,      1}, ROW_REQ, 32'h777, 7},
		'{'{OP_RESP,  0,  24'h0,      0,            32'hFFFFFFFF, 1}, ROW_DONE, 32'hFFFFFFFF, 0},
		'{'{OP_LOAD,  12, 24'h000042, 0,            0,            0}, ROW_PREDICT, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      65802,        0,            0}, ROW_REQ, 32'h42, 0},
		'{'{OP_RESP,  0,  24'h0,      0,            0,            1}, ROW_DONE, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      65802,        0,            0}, ROW_PREDICT, 0, 0},
		'{'{OP_RESP,  0,  24'h0,      0,            32'h55,       0}, ROW_DONE, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      15,           0,            0}, ROW_PREDICT, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      0,            0,            0}, ROW_DONE, 32'hFFFFFF, 0},
		'{'{OP_RESP,  0,  24'h0,      0,            9,            1}, ROW_QUIET, 0, 0},
		'{'{OP_XLATE, 0,  24'h0,      16843017,     0,            0}, ROW_REQ, 32'h42, 255}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	logic [OP_W-1:0]      operation = '0;
	logic [3:0]           slot_index = '0;
	logic [SLOT_W-1:0]    slot_value = '0;
	logic [BLK_W-1:0]     logical_block = '0;
	logic [BLK_W-1:0]     read_value = '0;
	logic                 read_ok = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic                 result_kind;
	logic [BLK_W-1:0]     request_block;
	logic [WORD_W-1:0]    request_word;
	logic [BLK_W-1:0]     physical_block;
	logic                 out_of_range;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	indirect_block_map_walker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.operation     (operation),
		.slot_index    (slot_index),
		.slot_value    (slot_value),
		.logical_block (logical_block),
		.read_value    (read_value),
		.read_ok       (read_ok),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_kind   (result_kind),
		.request_block (request_block),
		.request_word  (request_word),
		.physical_block(physical_block),
		.out_of_range  (out_of_range),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// walk predictor state
	logic [SLOT_W-1:0] slot_mem [SLOT_COUNT];
	bit                walk_on;
	logic [1:0]        lvl_left;
	logic [BLK_W-1:0]  walk_off;
	logic [CFG_W-1:0]  dc_reg = DIRECT_COUNT_RST;
	logic [CFG_W-1:0]  pl_reg = POINTERS_LOG2_RST;

	map_res_t awaited_answers [$];
	int       mismatches, cycle_count, rx_left, gap_calls;
	int       n_results, n_reqs, n_holes, n_oor, n_sent;
	bit       tx_calm;

	initial begin
		foreach (slot_mem[i])
			slot_mem[i] = '0;
	end

	function automatic int direct_slots();
		return (dc_reg > MAX_DIRECT) ? int'(MAX_DIRECT) : int'(dc_reg);
	endfunction

	function automatic int ptr_shift();
		if (pl_reg < MIN_PL)
			return int'(MIN_PL);
		return (pl_reg > MAX_PL) ? int'(MAX_PL) : int'(pl_reg);
	endfunction

	// pointer index for the level about to be read
	function automatic logic [WORD_W-1:0] ptr_index(logic [BLK_W-1:0] off, int lv, int pl);
		int sh;
		sh = pl * ((lv - 1) & 3);
		return WORD_W'((off >> sh) & ((32'd1 << pl) - 1));
	endfunction

	function automatic bit translate_step(input map_item_t it, output map_res_t r);
		longint unsigned per, lbn;
		int d, lv;
		logic [SLOT_W-1:0] root;
		r = '0;
		case (it.op)
		OP_LOAD: begin
			if (it.idx < SLOT_COUNT)
				slot_mem[it.idx] = it.sval;
			return 1'b0;
		end
		OP_XLATE: begin
			d = direct_slots();
			per = 64'd1 << ptr_shift();
			lbn = 64'(it.lbn);
			walk_on = 1'b0;
			lvl_left = '0;
			r.kind = KIND_DONE;
			if (lbn < d) begin
				r.phys = BLK_W'(slot_mem[lbn[3:0]]);
				return 1'b1;
			end
			lbn -= d;
			if (lbn < per) begin
				root = slot_mem[d];
				lv = 1;
			end else begin
				lbn -= per;
				if (lbn < per * per) begin
					root = slot_mem[d + 1];
					lv = 2;
				end else begin
					lbn -= per * per;
					if (lbn >= per * per * per) begin
						r.oor = 1'b1;
						return 1'b1;
					end
					root = slot_mem[d + 2];
					lv = 3;
				end
			end
			if (root == '0)
				return 1'b1;
			walk_on = 1'b1;
			lvl_left = 2'(lv);
			walk_off = lbn[31:0];
			r.kind = KIND_REQ;
			r.blk = BLK_W'(root);
			r.word = ptr_index(walk_off, lv, ptr_shift());
			return 1'b1;
		end
		OP_RESP: begin
			if (!walk_on)
				return 1'b0;
			if (!it.ok || it.rv == '0 || lvl_left <= 2'd1) begin
				walk_on = 1'b0;
				lvl_left = '0;
				r.kind = KIND_DONE;
				r.phys = it.ok ? it.rv : '0;
				return 1'b1;
			end
			lvl_left = lvl_left - 2'd1;
			r.kind = KIND_REQ;
			r.blk = it.rv;
			r.word = ptr_index(walk_off, lvl_left, ptr_shift());
			return 1'b1;
		end
		default:
			return 1'b0;
		endcase
	endfunction

	function automatic int pick_gap();
		int sel;
		gap_calls++;
		if (gap_calls % 64 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
		if (tx_calm)
			return 0;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	// logical block aimed at one region of the map under the current settings
	function automatic logic [BLK_W-1:0] pick_block_number();
		longint unsigned per, s0, s1, s2, s3, lo, hi;
		longint unsigned edges [8];
		int pick;
		per = 64'd1 << ptr_shift();
		s0 = direct_slots();
		s1 = s0 + per;
		s2 = s1 + per * per;
		s3 = s2 + per * per * per;
		pick = $urandom_range(0, 15);
		case (pick)
		0, 1: begin
			lo = 0;
			hi = s0 + 2;
		end
		2, 3, 4: begin
			lo = s0;
			hi = s1 - 1;
		end
		5, 6, 7: begin
			lo = s1;
			hi = s2 - 1;
		end
		8, 9, 10: begin
			lo = s2;
			hi = s3 - 1;
		end
		11: begin
			lo = s3;
			hi = 64'hFFFF_FFFF;
		end
		12:
			return $urandom;
		default: begin
			edges[0] = s0;
			edges[1] = s1 - 1;
			edges[2] = s1;
			edges[3] = s2 - 1;
			edges[4] = s2;
			edges[5] = s3 - 1;
			edges[6] = s3;
			edges[7] = 64'hFFFF_FFFF;
			return BLK_W'(edges[$urandom_range(0, 7)]);
		end
		endcase
		return BLK_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
	endfunction

	// mostly well-formed walks: while a walk is open, answer its pointer reads
	function automatic map_item_t pick_request();
		map_item_t it;
		int sel;
		it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
		sel = $urandom_range(0, 99);
		if (walk_on) begin
			if (sel < 85)
				it.op = OP_RESP;
			else if (sel < 92)
				it.op = OP_XLATE;
			else if (sel < 98)
				it.op = OP_LOAD;
			else
				it.op = OP_UNUSED;
		end else begin
			if (sel < 50)
				it.op = OP_XLATE;
			else if (sel < 88)
				it.op = OP_LOAD;
			else if (sel < 96)
				it.op = OP_RESP;
			else
				it.op = OP_UNUSED;
		end
		case (it.op)
		OP_LOAD: begin
			sel = $urandom_range(0, 19);
			if (sel < 2)
				it.sval = '0;
			else if (sel == 2)
				it.sval = '1;
		end
		OP_XLATE:
			it.lbn = pick_block_number();
		OP_RESP: begin
			it.ok = ($urandom_range(0, 19) != 0);
			sel = $urandom_range(0, 99);
			if (sel < 5)
				it.rv = '0;
			else if (sel < 8)
				it.rv = '1;
		end
		default: ;
		endcase
		return it;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// valid is raised without a drop when the next request follows at once
	task automatic send_item(input map_item_t it, input int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation     <= it.op;
		slot_index    <= it.idx;
		slot_value    <= it.sval;
		logical_block <= it.lbn;
		read_value    <= it.rv;
		read_ok       <= it.ok;
		item_valid    <= 1'b1;
		do @(posedge clk); while (item_stall);
		n_sent++;
	endtask

	task automatic log_accept(input map_item_t it, input row_chk_e chk, input map_res_t typed);
		map_res_t r;
		bit got;
		got = translate_step(it, r);
		if (chk == ROW_PREDICT) begin
			if (got)
				awaited_answers.push_back(r);
		end else if (chk != ROW_QUIET) begin
			awaited_answers.push_back(typed);
		end
	endtask

	// empty pipeline: requests that produce nothing may still be in flight
	task automatic settle();
		item_valid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] dc, input logic [CFG_W-1:0] pl);
		cfg_index <= CFG_DIRECT_COUNT;
		cfg_data  <= dc;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		dc_reg = dc;
		cfg_index <= CFG_POINTERS_LOG2;
		cfg_data  <= pl;
		do @(posedge clk); while (!cfg_ready);
		pl_reg = pl;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_answers.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: check against the oldest expectation, then pick the next stall
	always @(posedge clk) begin
		map_res_t e;
		int sel;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			n_results++;
			if (result_kind === KIND_REQ)
				n_reqs++;
			else if (out_of_range === 1'b1)
				n_oor++;
			else if (physical_block === '0)
				n_holes++;
			if (awaited_answers.size() == 0) begin
				flag_mismatch("result with nothing awaited");
			end else begin
				e = awaited_answers.pop_front();
				if (result_kind !== e.kind)
					flag_mismatch($sformatf("result_kind %0b, want %0b", result_kind, e.kind));
				if (request_block !== e.blk)
					flag_mismatch($sformatf("request_block %h, want %h", request_block, e.blk));
				if (request_word !== e.word)
					flag_mismatch($sformatf("request_word %0d, want %0d", request_word, e.word));
				if (physical_block !== e.phys)
					flag_mismatch($sformatf("physical_block %h, want %h",
						physical_block, e.phys));
				if (out_of_range !== e.oor)
					flag_mismatch($sformatf("out_of_range %0b, want %0b", out_of_range, e.oor));
			end
		end
		if (rx_left == 0) begin
			sel = $urandom_range(0, 15);
			if (sel == 0) begin
				result_stall <= 1'b0;
				rx_left = $urandom_range(40, 150);
			end else if (sel < 10) begin
				result_stall <= 1'b0;
				rx_left = $urandom_range(0, 3);
			end else if (sel < 15) begin
				result_stall <= 1'b1;
				rx_left = $urandom_range(0, 3);
			end else begin
				result_stall <= 1'b1;
				rx_left = $urandom_range(8, 30);
			end
		end else begin
			rx_left--;
		end
	end

	initial begin
		map_item_t it;
		map_res_t typed;
		int counted;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			typed = '0;
			if (DIRECTED[i].chk == ROW_DONE) begin
				typed.kind = KIND_DONE;
				typed.phys = DIRECTED[i].va;
				typed.oor  = DIRECTED[i].vb[0];
			end else if (DIRECTED[i].chk == ROW_REQ) begin
				typed.kind = KIND_REQ;
				typed.blk  = DIRECTED[i].va;
				typed.word = DIRECTED[i].vb;
			end
			send_item(DIRECTED[i].it, pick_gap());
			log_accept(DIRECTED[i].it, DIRECTED[i].chk, typed);
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			program_regs(PHASE_DC[p], PHASE_PL[p]);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				it = pick_request();
				counted++;
				send_item(it, pick_gap());
				log_accept(it, ROW_PREDICT, '0);
			end
		end
		settle();

		$display("Sent %0d requests (%0d directed) over %0d register settings.",
			n_sent, $size(DIRECTED), PHASES + 1);
		$display("Checked %0d results: %0d pointer reads, %0d holes, %0d out of range.",
			n_results, n_reqs, n_holes, n_oor);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
